@@ sv/bapd_pkg.sv @@
`timescale 1ns / 1ps
// Package for the barometric apogee detector: sizes, codes, sequencer states
// and saturation helpers. No dependencies.
package bapd_pkg;

    localparam int SEG        = 64;
    localparam int SEG_BITS   = $clog2(SEG);
    localparam int SEG_AW     = $clog2(SEG + 1);
    localparam int RATIO_BITS = 17;
    localparam int FRAC_W     = RATIO_BITS - SEG_BITS;
    localparam int NODE_W     = RATIO_BITS + 1;

    localparam int APOGEE_TICKS  = 3;
    localparam int LANDING_TICKS = 10;

    localparam int BARO_SCALE = 44330;
    localparam int VEL_SCALE  = 1000000;
    localparam int EXP_NUM    = 1000;
    localparam int EXP_DEN    = 5255;

    localparam int DIV_W = 48;
    localparam int DEN_W = 24;
    localparam int LOG_STEPS = 24;

    localparam logic signed [23:0] MAX24 = 24'sh7FFFFF;
    localparam logic signed [23:0] MIN24 = 24'sh800000;

    typedef enum logic [1:0] {
        OP_UPDATE    = 2'd0,
        OP_CALIBRATE = 2'd1,
        OP_RESET     = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ASCENT  = 2'd1,
        PH_APOGEE  = 2'd2,
        PH_DESCENT = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        REG_ALPHA      = 3'd0,
        REG_P0         = 3'd1,
        REG_TO_ALT     = 3'd2,
        REG_TO_VEL     = 3'd3,
        REG_APOGEE_VEL = 3'd4,
        REG_LAND_ALT   = 3'd5,
        REG_LAND_VEL   = 3'd6
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_B_INIT,
        ST_B_SEG,
        ST_B_KLOG,
        ST_B_EMUL,
        ST_B_EDIV,
        ST_B_E,
        ST_B_SRCH,
        ST_B_CMP,
        ST_LOG_SQ,
        ST_LOG_NORM,
        ST_DIV,
        ST_IDLE,
        ST_RATIO,
        ST_LK0,
        ST_LK1,
        ST_LK2,
        ST_LK3,
        ST_LK4,
        ST_LK5,
        ST_EMA0,
        ST_EMA1,
        ST_EMA2,
        ST_VMUL,
        ST_VDIV,
        ST_VEL,
        ST_DONE
    } state_t;

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        logic signed [23:0] r;
        if (v > 48'(MAX24))
            r = MAX24;
        else if (v < 48'(MIN24))
            r = MIN24;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage

@@ sv/barometric_apogee_detector.sv @@
`timescale 1ns / 1ps
// Barometric apogee detector: pressure to altitude, EMA filter, velocity and
// flight phase, all on one shared multiplier and one shared divider. Uses bapd_pkg.
//
//  channel  | dir | handshake                    | contents
//  ---------+-----+------------------------------+-------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser op, tdata pressure, dt
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata result word
//  cfg      | in  | cfg_we                       | cfg_index, cfg_data
//
// After reset the power-curve node table is built by the sequencer (each node:
// a log2 per binary search step); no word is taken meanwhile. An update uses
// the divider for the pressure ratio and the velocity, a calibration for the
// pressure ratio only; a flight reset or an ignored word goes straight to the
// result. One word is worked on at a time; the result register lets the next
// word in while the previous result is stalled.
module barometric_apogee_detector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // pressure[16:0], delta_time[40:17]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // altitude[23:0], velocity[47:24],
                                        // phase[49:48], apogee_reached[50],
                                        // max_altitude[74:51], ignored[75]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int AW = bapd_pkg::SEG_AW;
    localparam int NW = bapd_pkg::NODE_W;

    // configuration
    logic [16:0]        alpha_reg;
    logic [16:0]        p0_reg;
    logic signed [23:0] to_alt_reg;
    logic signed [23:0] to_vel_reg;
    logic signed [23:0] ap_vel_reg;
    logic signed [23:0] land_alt_reg;
    logic [22:0]        land_vel_reg;

    // sequencer
    bapd_pkg::state_t state_reg, state_next;
    bapd_pkg::state_t ret_reg, ret_next;

    // shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] product_reg;

    // shared divider
    logic [bapd_pkg::DIV_W-1:0] quot_reg, quot_next;
    logic [bapd_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [bapd_pkg::DEN_W-1:0] den_reg, den_next;
    logic [5:0]                 dcnt_reg, dcnt_next;
    logic [bapd_pkg::DEN_W:0]   rem_sh;

    // log2 engine
    logic [31:0] z_reg, z_next;
    logic [4:0]  m_reg, m_next;
    logic [23:0] frac_reg, frac_next;
    logic [4:0]  lcnt_reg, lcnt_next;
    logic [NW-1:0] log_in;
    logic [4:0]  log_m;
    logic [31:0] log_z0;
    logic [28:0] log_res;
    logic [31:0] sq;

    // table build
    logic [AW-1:0]      k_reg, k_next;
    logic [28:0]        seg_log_reg, seg_log_next;
    logic signed [31:0] l_reg, l_next;
    logic               neg_reg, neg_next;
    logic signed [39:0] e_reg, e_next;
    logic [NW-1:0]      lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [NW:0]        mid_sum;

    // node memory
    logic [NW-1:0] node_mem [0:bapd_pkg::SEG];
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [NW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [NW-1:0] rd_data_reg;

    // item path
    bapd_pkg::op_t      op_reg, op_next;
    logic [16:0]        p_reg, p_next;
    logic [23:0]        dt_reg, dt_next;
    logic [NW-1:0]      r_reg, r_next;
    logic [NW-1:0]      node_lo_reg, node_lo_next;
    logic [NW-1:0]      y_reg, y_next;
    logic signed [23:0] raw_reg, raw_next;
    logic signed [47:0] acc_reg, acc_next;
    logic signed [24:0] d_reg, d_next;
    logic [AW-1:0]      idx;
    logic [16:0]        frac_pos;
    logic [16:0]        a_lim;
    logic signed [65:0] pround;
    logic signed [23:0] abs_alt;
    logic signed [23:0] filt_new;
    logic [24:0]        d_mag;
    logic signed [23:0] v_new;
    logic [24:0]        v_mag;
    logic [7:0]         ap_inc, land_inc;
    logic [65:0]        p_mag;

    // flight state
    bapd_pkg::phase_t   phase_reg, phase_next;
    logic signed [23:0] filt_reg, filt_next;
    logic signed [23:0] vel_reg, vel_next;
    logic signed [23:0] peak_reg, peak_next;
    logic signed [23:0] ground_reg, ground_next;
    logic [7:0]         ap_cnt_reg, ap_cnt_next;
    logic [7:0]         land_cnt_reg, land_cnt_next;
    logic               ign_reg, ign_next;
    logic               flight_rst;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [75:0] out_data_reg, out_data_next;

    assign s_axis_tready = (state_reg == bapd_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_data_reg};

    assign log_res = {m_reg, frac_reg};
    assign sq      = product_reg[61:30];
    assign rem_sh  = {rem_reg, quot_reg[bapd_pkg::DIV_W-1]};
    assign mid_sum = (NW+1)'(lo_reg) + (NW+1)'(hi_reg) + (NW+1)'(1);
    assign idx      = AW'(r_reg >> bapd_pkg::FRAC_W);
    assign frac_pos = 17'(r_reg[bapd_pkg::FRAC_W-1:0]) << bapd_pkg::SEG_BITS;
    assign a_lim    = (alpha_reg > 17'd65536) ? 17'd65536 : alpha_reg;
    assign d_mag    = d_reg[24] ? 25'(-d_reg) : 25'(d_reg);
    assign p_mag    = product_reg[65] ? 66'(-product_reg) : 66'(product_reg);

    always_comb
    begin
        log_m = '0;
        for (int i = 0; i < NW; i++)
        begin
            if (log_in[i])
                log_m = 5'(i);
        end
    end
    assign log_z0 = 32'(log_in) << (5'd30 - log_m);

    always_comb
    begin
        pround   = product_reg + 66'sd128;
        abs_alt  = bapd_pkg::sat24(48'(pround >>> 8));
        filt_new = bapd_pkg::sat24(48'((66'(acc_reg) + product_reg + 66'sd32768) >>> 16));
        if (!d_reg[24])
            v_new = (quot_reg > 48'(bapd_pkg::MAX24)) ? bapd_pkg::MAX24 : quot_reg[23:0];
        else if (quot_reg > 48'd8388608)
            v_new = bapd_pkg::MIN24;
        else
            v_new = 24'(-quot_reg);
        v_mag    = v_new[23] ? 25'(-26'(v_new)) : 25'(v_new);
        ap_inc   = (ap_cnt_reg == 8'd255) ? 8'd255 : ap_cnt_reg + 8'd1;
        land_inc = (land_cnt_reg == 8'd255) ? 8'd255 : land_cnt_reg + 8'd1;
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        dcnt_next      = dcnt_reg;
        z_next         = z_reg;
        m_next         = m_reg;
        frac_next      = frac_reg;
        lcnt_next      = lcnt_reg;
        k_next         = k_reg;
        seg_log_next   = seg_log_reg;
        l_next         = l_reg;
        neg_next       = neg_reg;
        e_next         = e_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        op_next        = op_reg;
        p_next         = p_reg;
        dt_next        = dt_reg;
        r_next         = r_reg;
        node_lo_next   = node_lo_reg;
        y_next         = y_reg;
        raw_next       = raw_reg;
        acc_next       = acc_reg;
        d_next         = d_reg;
        phase_next     = phase_reg;
        filt_next      = filt_reg;
        vel_next       = vel_reg;
        peak_next      = peak_reg;
        ground_next    = ground_reg;
        ap_cnt_next    = ap_cnt_reg;
        land_cnt_next  = land_cnt_reg;
        ign_next       = ign_reg;
        flight_rst     = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        mul_a          = '0;
        mul_b          = '0;
        log_in         = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_addr        = idx;

        unique case (state_reg)
            bapd_pkg::ST_B_INIT:
            begin
                wr_en      = 1'b1;
                k_next     = AW'(1);
                log_in     = NW'(bapd_pkg::SEG);
                z_next     = log_z0;
                m_next     = log_m;
                frac_next  = '0;
                lcnt_next  = '0;
                ret_next   = bapd_pkg::ST_B_SEG;
                state_next = bapd_pkg::ST_LOG_SQ;
            end
            bapd_pkg::ST_B_SEG:
            begin
                seg_log_next = log_res;
                log_in       = NW'(k_reg);
                z_next       = log_z0;
                m_next       = log_m;
                frac_next    = '0;
                lcnt_next    = '0;
                ret_next     = bapd_pkg::ST_B_KLOG;
                state_next   = bapd_pkg::ST_LOG_SQ;
            end
            bapd_pkg::ST_B_KLOG:
            begin
                l_next = 32'sd16777216 + $signed({3'b0, log_res})
                       - $signed({3'b0, seg_log_reg});
                state_next = bapd_pkg::ST_B_EMUL;
            end
            bapd_pkg::ST_B_EMUL:
            begin
                mul_a      = 33'(l_reg);
                mul_b      = 33'(bapd_pkg::EXP_NUM);
                state_next = bapd_pkg::ST_B_EDIV;
            end
            bapd_pkg::ST_B_EDIV:
            begin
                neg_next   = product_reg[65];
                quot_next  = p_mag[bapd_pkg::DIV_W-1:0];
                rem_next   = '0;
                den_next   = bapd_pkg::DEN_W'(bapd_pkg::EXP_DEN);
                dcnt_next  = '0;
                ret_next   = bapd_pkg::ST_B_E;
                state_next = bapd_pkg::ST_DIV;
            end
            bapd_pkg::ST_B_E:
            begin
                e_next     = neg_reg ? -$signed(40'(quot_reg)) : $signed(40'(quot_reg));
                lo_next    = '0;
                hi_next    = NW'(1) << bapd_pkg::RATIO_BITS;
                state_next = bapd_pkg::ST_B_SRCH;
            end
            bapd_pkg::ST_B_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_sum[NW:1];
                    log_in     = mid_sum[NW:1];
                    z_next     = log_z0;
                    m_next     = log_m;
                    frac_next  = '0;
                    lcnt_next  = '0;
                    ret_next   = bapd_pkg::ST_B_CMP;
                    state_next = bapd_pkg::ST_LOG_SQ;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = k_reg;
                    wr_data = lo_reg;
                    if (k_reg == AW'(bapd_pkg::SEG))
                    begin
                        state_next = bapd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + AW'(1);
                        log_in     = NW'(k_reg + AW'(1));
                        z_next     = log_z0;
                        m_next     = log_m;
                        frac_next  = '0;
                        lcnt_next  = '0;
                        ret_next   = bapd_pkg::ST_B_KLOG;
                        state_next = bapd_pkg::ST_LOG_SQ;
                    end
                end
            end
            bapd_pkg::ST_B_CMP:
            begin
                if ($signed({11'b0, log_res}) - 40'sd268435456 <= e_reg)
                    lo_next = mid_reg;
                else
                    hi_next = mid_reg - NW'(1);
                state_next = bapd_pkg::ST_B_SRCH;
            end
            bapd_pkg::ST_LOG_SQ:
            begin
                mul_a      = 33'(z_reg);
                mul_b      = 33'(z_reg);
                state_next = bapd_pkg::ST_LOG_NORM;
            end
            bapd_pkg::ST_LOG_NORM:
            begin
                // renormalize into [1,2) and shift out one fraction bit
                if (sq[31])
                begin
                    z_next = sq >> 1;
                    frac_next[5'd23 - lcnt_reg] = 1'b1;
                end
                else
                begin
                    z_next = sq;
                end
                lcnt_next = lcnt_reg + 5'd1;
                if (lcnt_reg == 5'(bapd_pkg::LOG_STEPS - 1))
                    state_next = ret_reg;
                else
                    state_next = bapd_pkg::ST_LOG_SQ;
            end
            bapd_pkg::ST_DIV:
            begin
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next  = bapd_pkg::DEN_W'(rem_sh - {1'b0, den_reg});
                    quot_next = {quot_reg[bapd_pkg::DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh[bapd_pkg::DEN_W-1:0];
                    quot_next = {quot_reg[bapd_pkg::DIV_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'(bapd_pkg::DIV_W - 1))
                    state_next = ret_reg;
            end
            bapd_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next  = bapd_pkg::op_t'(s_axis_tuser);
                    p_next   = s_axis_tdata[16:0];
                    dt_next  = s_axis_tdata[40:17];
                    ign_next = 1'b0;
                    unique case (bapd_pkg::op_t'(s_axis_tuser))
                        bapd_pkg::OP_RESET:
                        begin
                            flight_rst = 1'b1;
                            state_next = bapd_pkg::ST_DONE;
                        end
                        bapd_pkg::OP_NONE:
                        begin
                            ign_next   = 1'b1;
                            state_next = bapd_pkg::ST_DONE;
                        end
                        bapd_pkg::OP_UPDATE, bapd_pkg::OP_CALIBRATE:
                        begin
                            if (bapd_pkg::op_t'(s_axis_tuser) == bapd_pkg::OP_UPDATE
                                && s_axis_tdata[40:17] == 24'd0)
                            begin
                                ign_next   = 1'b1;
                                state_next = bapd_pkg::ST_DONE;
                            end
                            else if (p0_reg == 17'd0)
                            begin
                                r_next     = NW'(1) << bapd_pkg::RATIO_BITS;
                                state_next = bapd_pkg::ST_LK0;
                            end
                            else
                            begin
                                quot_next  = bapd_pkg::DIV_W'({s_axis_tdata[16:0], 16'b0})
                                           + bapd_pkg::DIV_W'(p0_reg >> 1);
                                rem_next   = '0;
                                den_next   = bapd_pkg::DEN_W'(p0_reg);
                                dcnt_next  = '0;
                                ret_next   = bapd_pkg::ST_RATIO;
                                state_next = bapd_pkg::ST_DIV;
                            end
                        end
                        default:
                        begin
                            ign_next   = 1'b1;
                            state_next = bapd_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            bapd_pkg::ST_RATIO:
            begin
                if (quot_reg > (bapd_pkg::DIV_W'(1) << bapd_pkg::RATIO_BITS))
                    r_next = NW'(1) << bapd_pkg::RATIO_BITS;
                else
                    r_next = quot_reg[NW-1:0];
                state_next = bapd_pkg::ST_LK0;
            end
            bapd_pkg::ST_LK0:
            begin
                state_next = bapd_pkg::ST_LK1;
            end
            bapd_pkg::ST_LK1:
            begin
                node_lo_next = rd_data_reg;
                if (idx != AW'(bapd_pkg::SEG))
                    rd_addr = idx + AW'(1);
                state_next = bapd_pkg::ST_LK2;
            end
            bapd_pkg::ST_LK2:
            begin
                mul_a      = 33'($signed({1'b0, rd_data_reg}) - $signed({1'b0, node_lo_reg}));
                mul_b      = 33'(frac_pos);
                state_next = bapd_pkg::ST_LK3;
            end
            bapd_pkg::ST_LK3:
            begin
                if (idx == AW'(bapd_pkg::SEG))
                    y_next = node_lo_reg;
                else
                    y_next = node_lo_reg + NW'((product_reg + 66'sd65536) >>> 17);
                state_next = bapd_pkg::ST_LK4;
            end
            bapd_pkg::ST_LK4:
            begin
                mul_a      = 33'(bapd_pkg::BARO_SCALE);
                mul_b      = 33'(20'sd65536 - $signed({2'b0, y_reg}));
                state_next = bapd_pkg::ST_LK5;
            end
            bapd_pkg::ST_LK5:
            begin
                if (op_reg == bapd_pkg::OP_CALIBRATE)
                begin
                    ground_next = abs_alt;
                    flight_rst  = 1'b1;
                    state_next  = bapd_pkg::ST_DONE;
                end
                else
                begin
                    raw_next   = bapd_pkg::sat24(48'(abs_alt) - 48'(ground_reg));
                    state_next = bapd_pkg::ST_EMA0;
                end
            end
            bapd_pkg::ST_EMA0:
            begin
                mul_a      = 33'(a_lim);
                mul_b      = 33'(raw_reg);
                state_next = bapd_pkg::ST_EMA1;
            end
            bapd_pkg::ST_EMA1:
            begin
                acc_next   = 48'(product_reg);
                mul_a      = 33'(18'd65536 - 18'(a_lim));
                mul_b      = 33'(filt_reg);
                state_next = bapd_pkg::ST_EMA2;
            end
            bapd_pkg::ST_EMA2:
            begin
                filt_next = filt_new;
                d_next    = 25'(filt_new) - 25'(filt_reg);
                if (filt_new > peak_reg)
                    peak_next = filt_new;
                state_next = bapd_pkg::ST_VMUL;
            end
            bapd_pkg::ST_VMUL:
            begin
                mul_a      = 33'(d_mag);
                mul_b      = 33'(bapd_pkg::VEL_SCALE);
                state_next = bapd_pkg::ST_VDIV;
            end
            bapd_pkg::ST_VDIV:
            begin
                quot_next  = product_reg[bapd_pkg::DIV_W-1:0]
                           + bapd_pkg::DIV_W'(dt_reg >> 1);
                rem_next   = '0;
                den_next   = dt_reg;
                dcnt_next  = '0;
                ret_next   = bapd_pkg::ST_VEL;
                state_next = bapd_pkg::ST_DIV;
            end
            bapd_pkg::ST_VEL:
            begin
                vel_next = v_new;
                unique case (phase_reg)
                    bapd_pkg::PH_IDLE:
                    begin
                        if (filt_reg > to_alt_reg && v_new > to_vel_reg)
                            phase_next = bapd_pkg::PH_ASCENT;
                    end
                    bapd_pkg::PH_ASCENT:
                    begin
                        if (v_new < ap_vel_reg)
                        begin
                            ap_cnt_next = ap_inc;
                            if (ap_inc >= 8'(bapd_pkg::APOGEE_TICKS))
                                phase_next = bapd_pkg::PH_APOGEE;
                        end
                        else
                        begin
                            ap_cnt_next = '0;
                        end
                    end
                    bapd_pkg::PH_APOGEE:
                    begin
                        phase_next = bapd_pkg::PH_DESCENT;
                    end
                    bapd_pkg::PH_DESCENT:
                    begin
                        if (filt_reg < land_alt_reg && v_mag < {2'b0, land_vel_reg})
                        begin
                            land_cnt_next = land_inc;
                            if (land_inc >= 8'(bapd_pkg::LANDING_TICKS))
                                flight_rst = 1'b1;
                        end
                        else
                        begin
                            land_cnt_next = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = bapd_pkg::PH_IDLE;
                    end
                endcase
                state_next = bapd_pkg::ST_DONE;
            end
            bapd_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {ign_reg, peak_reg,
                                      (phase_reg == bapd_pkg::PH_APOGEE
                                       || phase_reg == bapd_pkg::PH_DESCENT),
                                      phase_reg, vel_reg, filt_reg};
                    state_next     = bapd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bapd_pkg::ST_IDLE;
            end
        endcase

        if (flight_rst)
        begin
            phase_next    = bapd_pkg::PH_IDLE;
            filt_next     = '0;
            vel_next      = '0;
            peak_next     = '0;
            ap_cnt_next   = '0;
            land_cnt_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            node_mem[wr_addr] <= wr_data;
        rd_data_reg <= node_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg    <= 17'd13107;
            p0_reg       <= 17'd101325;
            to_alt_reg   <= 24'sd2560;
            to_vel_reg   <= 24'sd1280;
            ap_vel_reg   <= 24'sd0;
            land_alt_reg <= 24'sd1280;
            land_vel_reg <= 23'd256;
        end
        else if (cfg_we)
        begin
            case (bapd_pkg::reg_idx_t'(cfg_index))
                bapd_pkg::REG_ALPHA:      alpha_reg    <= cfg_data[16:0];
                bapd_pkg::REG_P0:         p0_reg       <= cfg_data[16:0];
                bapd_pkg::REG_TO_ALT:     to_alt_reg   <= cfg_data;
                bapd_pkg::REG_TO_VEL:     to_vel_reg   <= cfg_data;
                bapd_pkg::REG_APOGEE_VEL: ap_vel_reg   <= cfg_data;
                bapd_pkg::REG_LAND_ALT:   land_alt_reg <= cfg_data;
                bapd_pkg::REG_LAND_VEL:   land_vel_reg <= cfg_data[22:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bapd_pkg::ST_B_INIT;
            ret_reg       <= bapd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            phase_reg     <= bapd_pkg::PH_IDLE;
            filt_reg      <= '0;
            vel_reg       <= '0;
            peak_reg      <= '0;
            ground_reg    <= '0;
            ap_cnt_reg    <= '0;
            land_cnt_reg  <= '0;
            ign_reg       <= 1'b0;
            dcnt_reg      <= '0;
            lcnt_reg      <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            filt_reg      <= filt_next;
            vel_reg       <= vel_next;
            peak_reg      <= peak_next;
            ground_reg    <= ground_next;
            ap_cnt_reg    <= ap_cnt_next;
            land_cnt_reg  <= land_cnt_next;
            ign_reg       <= ign_next;
            dcnt_reg      <= dcnt_next;
            lcnt_reg      <= lcnt_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        z_reg        <= z_next;
        m_reg        <= m_next;
        frac_reg     <= frac_next;
        seg_log_reg  <= seg_log_next;
        l_reg        <= l_next;
        neg_reg      <= neg_next;
        e_reg        <= e_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        op_reg       <= op_next;
        p_reg        <= p_next;
        dt_reg       <= dt_next;
        r_reg        <= r_next;
        node_lo_reg  <= node_lo_next;
        y_reg        <= y_next;
        raw_reg      <= raw_next;
        acc_reg      <= acc_next;
        d_reg        <= d_next;
        out_data_reg <= out_data_next;
    end

endmodule
